// ===== design/ltp_pkg.sv =====
package ltp_pkg;

    // Default sizes of the task table.
    localparam int MAX_TASKS_DEF     = 16;
    localparam int TASK_ID_WIDTH_DEF = 8;

    // Fixed field widths.
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 8;
    localparam int TICKET_W = 16;
    localparam int RND_W    = 32;
    localparam int TOTAL_W  = 20;
    localparam int STATUS_W = 2;

    // The shared unit works on the partial remainder, which needs one bit over the total.
    localparam int ALU_W = TOTAL_W + 1;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PICK = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Input word.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [ID_W-1:0]     task_id;
        logic [TICKET_W-1:0] ticket_count;
        logic [RND_W-1:0]    random_value;
    } ltp_in_t;

    // Result word.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     winner_task;
        logic [TOTAL_W-1:0]  winning_ticket;
        logic [TOTAL_W-1:0]  ticket_total;
    } ltp_out_t;

    // Request to the shared add/subtract unit.
    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } ltp_alu_req_t;

    // Response of the shared add/subtract unit.
    typedef struct packed {
        logic [ALU_W-1:0] result;
        logic             borrow;
    } ltp_alu_rsp_t;

endpackage

// ===== design/ltp_ram.sv =====
module ltp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/ltp_alu.sv =====
module ltp_alu (
    input  ltp_pkg::ltp_alu_req_t req,
    output ltp_pkg::ltp_alu_rsp_t rsp
);

    logic [ltp_pkg::ALU_W:0] sum;

    // One extra bit on top gives the borrow of a subtraction.
    always_comb begin
        if (req.sub) begin
            sum = {1'b0, req.a} - {1'b0, req.b};
        end else begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.result = sum[ltp_pkg::ALU_W-1:0];
        rsp.borrow = req.sub & sum[ltp_pkg::ALU_W];
    end

endmodule

// ===== design/lottery_task_picker_top.sv =====
// Lottery task picker.
// Input words arrive on s_valid/s_ready/s_data, results leave on m_valid/m_ready/m_data,
// one result word for every input word, in order. The block holds an ordered table
// of queued tasks in a RAM and the running ticket total in a register.
// One word is in work at a time; s_ready is high only while the sequencer idles.
// Steps from acceptance to m_valid:
//   enqueue, or any operation that fails at once: the result goes straight to the done state.
//   dequeue: the table is scanned and then compacted one entry a cycle through the
//   single RAM port pair.
//   pick: a bit-serial remainder on the shared adder, then a walk of one
//   entry a cycle.
// The result sits in an output register; the next word is accepted while it waits.
// If m_ready stays low, a second finished result holds in the sequencer until the
// output register frees, and no further word is accepted meanwhile.
// Synchronous reset empties the table and clears the total; the RAM is not cleared,
// since only entries below the queue count are ever used.
module lottery_task_picker_top #(
    parameter int MAX_TASKS     = ltp_pkg::MAX_TASKS_DEF,
    parameter int TASK_ID_WIDTH = ltp_pkg::TASK_ID_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ltp_pkg::ltp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ltp_pkg::ltp_out_t m_data
);

    localparam int IDX_W   = $clog2(MAX_TASKS);
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int ENT_W   = TASK_ID_WIDTH + ltp_pkg::TICKET_W;
    localparam int BIT_W   = $clog2(ltp_pkg::RND_W);
    localparam int IDW     = TASK_ID_WIDTH;
    localparam int TW      = ltp_pkg::TOTAL_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SEARCH = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_WALK   = 7'b0010000,
        S_DONE   = 7'b0100000,
        S_SPARE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [IDW-1:0]               id_reg, id_next;
    logic [ltp_pkg::RND_W-1:0]    dvd_reg, dvd_next;
    logic [BIT_W-1:0]             bit_reg, bit_next;
    logic [TW-1:0]                rem_reg, rem_next;
    logic [CNT_W-1:0]             idx_reg, idx_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [TW-1:0]                total_reg, total_next;
    logic [ltp_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [IDW-1:0]               winner_reg, winner_next;
    logic [TW-1:0]                wticket_reg, wticket_next;
    ltp_pkg::ltp_out_t            out_reg, out_next;
    logic                         out_valid_reg, out_valid_next;

    logic [IDW+ltp_pkg::ID_W-1:0] in_id_wide;
    logic [IDW-1:0]               in_id;
    logic [IDW+ltp_pkg::ID_W-1:0] win_wide;
    logic [CNT_W-1:0]             idx_inc;
    logic                         accept;
    logic                         full;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ENT_W-1:0]             ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [ENT_W-1:0]             ram_rdata;
    logic [IDW-1:0]               rd_id;
    logic [ltp_pkg::TICKET_W-1:0] rd_tickets;

    ltp_pkg::ltp_alu_req_t        alu_req;
    ltp_pkg::ltp_alu_rsp_t        alu_rsp;

    // Only the low TASK_ID_WIDTH bits of an id are kept.
    assign in_id_wide = {{IDW{1'b0}}, s_data.task_id};
    assign in_id      = in_id_wide[IDW-1:0];
    assign win_wide   = {{ltp_pkg::ID_W{1'b0}}, winner_reg};

    assign rd_id      = ram_rdata[IDW-1:0];
    assign rd_tickets = ram_rdata[ENT_W-1:IDW];

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign idx_inc = idx_reg + CNT_W'(1);
    assign full    = (count_reg == CNT_W'(MAX_TASKS));

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    ltp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    ltp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // The read address follows the next index, so the entry at idx_reg is on ram_rdata in the same cycle as idx_reg.
    assign ram_raddr = idx_next[IDX_W-1:0];

    // Operand selection for the shared add/subtract unit.
    always_comb begin
        alu_req = '0;
        case (state_reg)
            S_IDLE: begin
                alu_req.sub = 1'b0;
                alu_req.a   = {1'b0, total_reg};
                alu_req.b   = ltp_pkg::ALU_W'(s_data.ticket_count);
            end
            S_SEARCH: begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, total_reg};
                alu_req.b   = ltp_pkg::ALU_W'(rd_tickets);
            end
            S_DIV: begin
                alu_req.sub = 1'b1;
                alu_req.a   = {rem_reg, dvd_reg[ltp_pkg::RND_W-1]};
                alu_req.b   = {1'b0, total_reg};
            end
            S_WALK: begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, rem_reg};
                alu_req.b   = ltp_pkg::ALU_W'(rd_tickets);
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        id_next        = id_reg;
        dvd_next       = dvd_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        status_next    = status_reg;
        winner_next    = winner_reg;
        wticket_next   = wticket_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[IDX_W-1:0];
        ram_wdata      = ram_rdata;

        // The output register empties when the receiver takes the word.
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    id_next      = in_id;
                    dvd_next     = s_data.random_value;
                    bit_next     = '0;
                    rem_next     = '0;
                    idx_next     = '0;
                    winner_next  = '0;
                    wticket_next = '0;
                    status_next  = ltp_pkg::ST_NONE;
                    state_next   = S_DONE;
                    case (s_data.func)
                        ltp_pkg::FUNC_ENQ: begin
                            if (full) begin
                                status_next = ltp_pkg::ST_FULL;
                            end else begin
                                ram_we      = 1'b1;
                                ram_waddr   = count_reg[IDX_W-1:0];
                                ram_wdata   = {s_data.ticket_count, in_id};
                                count_next  = count_reg + CNT_W'(1);
                                total_next  = alu_rsp.result[TW-1:0];
                                status_next = ltp_pkg::ST_OK;
                            end
                        end
                        ltp_pkg::FUNC_DEQ: begin
                            if (count_reg == '0) begin
                                status_next = ltp_pkg::ST_NOTFOUND;
                            end else begin
                                state_next = S_SEARCH;
                            end
                        end
                        ltp_pkg::FUNC_PICK: begin
                            if (count_reg != '0 && total_reg != '0) begin
                                state_next = S_DIV;
                            end
                        end
                        default: begin
                            status_next = ltp_pkg::ST_NONE;
                        end
                    endcase
                end
            end

            // Scan for the first matching id.
            S_SEARCH: begin
                idx_next = idx_inc;
                if (rd_id == id_reg) begin
                    total_next = alu_rsp.result[TW-1:0];
                    if (idx_inc == count_reg) begin
                        count_next  = count_reg - CNT_W'(1);
                        status_next = ltp_pkg::ST_OK;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SHIFT;
                    end
                end else if (idx_inc == count_reg) begin
                    status_next = ltp_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end

            // Move each later entry down by one place.
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[IDX_W-1:0] - IDX_W'(1);
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
                if (idx_inc == count_reg) begin
                    idx_next    = idx_reg;
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ltp_pkg::ST_OK;
                    state_next  = S_DONE;
                end
            end

            // Restoring remainder, one dividend bit a cycle.
            S_DIV: begin
                dvd_next = dvd_reg << 1;
                bit_next = bit_reg + BIT_W'(1);
                if (alu_rsp.borrow) begin
                    rem_next = alu_req.a[TW-1:0];
                end else begin
                    rem_next = alu_rsp.result[TW-1:0];
                end
                if (bit_reg == BIT_W'(ltp_pkg::RND_W - 1)) begin
                    wticket_next = rem_next;
                    state_next   = S_WALK;
                end
            end

            // The remaining ticket count drops below zero at the winning entry.
            S_WALK: begin
                if (alu_rsp.borrow) begin
                    winner_next = rd_id;
                    status_next = ltp_pkg::ST_OK;
                    state_next  = S_DONE;
                end else begin
                    rem_next = alu_rsp.result[TW-1:0];
                    idx_next = idx_inc;
                    if (idx_inc == count_reg) begin
                        idx_next    = idx_reg;
                        status_next = ltp_pkg::ST_NONE;
                        state_next  = S_DONE;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.status         = status_reg;
                    out_next.winner_task    = win_wide[ltp_pkg::ID_W-1:0];
                    out_next.winning_ticket = wticket_reg;
                    out_next.ticket_total   = total_reg;
                    out_valid_next          = 1'b1;
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        id_reg      <= id_next;
        dvd_reg     <= dvd_next;
        bit_reg     <= bit_next;
        rem_reg     <= rem_next;
        idx_reg     <= idx_next;
        status_reg  <= status_next;
        winner_reg  <= winner_next;
        wticket_reg <= wticket_next;
        out_reg     <= out_next;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // The one operation code the package leaves unnamed.
    localparam logic [ltp_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int TABLE_DEPTH = ltp_pkg::MAX_TASKS_DEF;
    localparam int WORDS_PER_PHASE = 400;
    localparam int NUM_PHASES = 4;

    // A queued stimulus word, optionally held back until the block has drained.
    typedef struct packed {
        ltp_pkg::ltp_in_t word;
        logic             drain_first;
    } pending_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    ltp_pkg::ltp_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    ltp_pkg::ltp_out_t m_data;

    // Stimulus and checking state.
    pending_word_t             pending_words[$];
    ltp_pkg::ltp_out_t         expected_results[$];
    logic [ltp_pkg::ID_W-1:0]  planned_ids[$];
    int unsigned               words_sent = 0;
    int unsigned               results_seen = 0;
    int unsigned               mismatch_count = 0;
    int unsigned               sender_idle_pct = 0;
    int unsigned               receiver_stall_pct = 0;
    ltp_pkg::ltp_out_t         oldest_result;

    // Scheduler table as the predictor sees it.
    logic [ltp_pkg::ID_W-1:0]     sched_id[TABLE_DEPTH];
    logic [ltp_pkg::TICKET_W-1:0] sched_tickets[TABLE_DEPTH];
    int unsigned                  sched_count = 0;
    logic [ltp_pkg::TOTAL_W-1:0]  sched_total = '0;

    lottery_task_picker_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // Apply one operation to the scheduler table and return the result it yields.
    function automatic ltp_pkg::ltp_out_t predict_outcome(ltp_pkg::ltp_in_t w);
        ltp_pkg::ltp_out_t r;
        int                pos;
        int                i;
        int unsigned       acc;
        bit                found;
        r = '0;
        r.status = ltp_pkg::ST_NONE;
        case (w.func)
            ltp_pkg::FUNC_ENQ: begin
                if (sched_count >= TABLE_DEPTH) begin
                    r.status = ltp_pkg::ST_FULL;
                end else begin
                    sched_id[sched_count] = w.task_id;
                    sched_tickets[sched_count] = w.ticket_count;
                    sched_count++;
                    sched_total = sched_total + ltp_pkg::TOTAL_W'(w.ticket_count);
                    r.status = ltp_pkg::ST_OK;
                end
            end
            ltp_pkg::FUNC_DEQ: begin
                pos = -1;
                for (i = 0; i < sched_count && pos < 0; i++) begin
                    if (sched_id[i] == w.task_id) pos = i;
                end
                if (pos < 0) begin
                    r.status = ltp_pkg::ST_NOTFOUND;
                end else begin
                    sched_total = sched_total - ltp_pkg::TOTAL_W'(sched_tickets[pos]);
                    for (i = pos; i + 1 < sched_count; i++) begin
                        sched_id[i] = sched_id[i + 1];
                        sched_tickets[i] = sched_tickets[i + 1];
                    end
                    sched_count--;
                    r.status = ltp_pkg::ST_OK;
                end
            end
            ltp_pkg::FUNC_PICK: begin
                if (sched_count != 0 && sched_total != 0) begin
                    r.winning_ticket =
                        ltp_pkg::TOTAL_W'(w.random_value % 32'(sched_total));
                    acc = 0;
                    found = 1'b0;
                    for (i = 0; i < sched_count && !found; i++) begin
                        acc += sched_tickets[i];
                        if (acc > r.winning_ticket) begin
                            r.winner_task = sched_id[i];
                            r.status = ltp_pkg::ST_OK;
                            found = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.ticket_total = sched_total;
        return r;
    endfunction

    // Queue one word and track which ids the plan expects to be in the table.
    task automatic add_word(logic [ltp_pkg::FUNC_W-1:0] f, logic [ltp_pkg::ID_W-1:0] id,
                            logic [ltp_pkg::TICKET_W-1:0] tix,
                            logic [ltp_pkg::RND_W-1:0] rnd, bit drain);
        pending_word_t p;
        int            k;
        bit            found;
        p.word.func = f;
        p.word.task_id = id;
        p.word.ticket_count = tix;
        p.word.random_value = rnd;
        p.drain_first = drain;
        pending_words.push_back(p);
        if (f == ltp_pkg::FUNC_ENQ && planned_ids.size() < TABLE_DEPTH) begin
            planned_ids.push_back(id);
        end else if (f == ltp_pkg::FUNC_DEQ) begin
            found = 1'b0;
            for (k = 0; k < planned_ids.size() && !found; k++) begin
                if (planned_ids[k] == id) begin
                    planned_ids.delete(k);
                    found = 1'b1;
                end
            end
        end
    endtask

    // Random operation, weighted so the table mostly stays partly filled.
    task automatic add_random_word(bit drain);
        logic [ltp_pkg::FUNC_W-1:0]   f;
        logic [ltp_pkg::ID_W-1:0]     id;
        logic [ltp_pkg::TICKET_W-1:0] tix;
        logic [ltp_pkg::RND_W-1:0]    rnd;
        int unsigned                  roll;
        int unsigned                  enq_limit;
        id = $urandom_range(255);
        tix = $urandom_range(65535);
        rnd = $urandom();
        enq_limit = (planned_ids.size() >= TABLE_DEPTH - 2) ? 25 : 45;
        roll = $urandom_range(99);
        if (roll < enq_limit) begin
            f = ltp_pkg::FUNC_ENQ;
            // Small ids make duplicates common.
            if ($urandom_range(9) < 7) id = $urandom_range(15);
            case ($urandom_range(9))
                0: tix = '0;
                1: tix = '1;
                2, 3, 4: tix = $urandom_range(15);
                default: ;
            endcase
        end else if (roll < enq_limit + 30) begin
            f = ltp_pkg::FUNC_DEQ;
            if (planned_ids.size() != 0 && $urandom_range(9) < 8) begin
                id = planned_ids[$urandom_range(planned_ids.size() - 1)];
            end
        end else if (roll < 97) begin
            f = ltp_pkg::FUNC_PICK;
            if ($urandom_range(3) == 0) rnd = $urandom_range(1 << 20);
        end else begin
            f = FUNC_UNUSED;
        end
        add_word(f, id, tix, rnd, drain);
    endtask

    // Input driver: presents pending words and records a prediction at each acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_outcome(s_data));
                words_sent <= words_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0
                        && !(pending_words[0].drain_first
                             && (words_sent != results_seen || (s_valid && s_ready)))
                        && $urandom_range(99) >= sender_idle_pct) begin
                    s_data <= pending_words[0].word;
                    pending_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each result taken from the block with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result with nothing expected:", $realtime);
                        $display("%0t: status %0d task %0d ticket %0d total %0d",
                                 $realtime, m_data.status, m_data.winner_task,
                                 m_data.winning_ticket, m_data.ticket_total);
                    end
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (m_data.status != oldest_result.status
                            || m_data.winner_task != oldest_result.winner_task
                            || m_data.winning_ticket != oldest_result.winning_ticket
                            || m_data.ticket_total != oldest_result.ticket_total) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: expected status %0d task %0d ticket %0d total %0d",
                                     $realtime, oldest_result.status,
                                     oldest_result.winner_task,
                                     oldest_result.winning_ticket,
                                     oldest_result.ticket_total);
                            $display("%0t: actual   status %0d task %0d ticket %0d total %0d",
                                     $realtime, m_data.status, m_data.winner_task,
                                     m_data.winning_ticket, m_data.ticket_total);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Stimulus plan: directed corner cases, then random phases with different idling.
    initial begin
        int unsigned sender_pct[NUM_PHASES];
        int unsigned receiver_pct[NUM_PHASES];
        int          p;
        int          n;
        sender_pct = '{0, 85, 0, 33};
        receiver_pct = '{0, 0, 85, 33};

        // Empty table: pick, dequeue and the unused code all fail cleanly.
        add_word(ltp_pkg::FUNC_PICK, 8'h5A, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        add_word(ltp_pkg::FUNC_DEQ, 8'h00, 16'h0000, 32'h0000_0000, 1'b0);
        add_word(FUNC_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        // A lone zero-ticket task leaves the total at zero.
        add_word(ltp_pkg::FUNC_ENQ, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        add_word(ltp_pkg::FUNC_PICK, 8'h00, 16'h0000, 32'h1234_5678, 1'b0);
        add_word(ltp_pkg::FUNC_ENQ, 8'hFF, 16'hFFFF, 32'h0000_0000, 1'b0);
        add_word(ltp_pkg::FUNC_PICK, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        // Duplicate id: dequeue must take the first one.
        add_word(ltp_pkg::FUNC_ENQ, 8'hFF, 16'h0001, 32'h0000_0000, 1'b0);
        add_word(ltp_pkg::FUNC_DEQ, 8'hFF, 16'h0000, 32'h0000_0000, 1'b0);
        // Winning ticket zero must skip the zero-ticket head entry.
        add_word(ltp_pkg::FUNC_PICK, 8'hFF, 16'hFFFF, 32'h0000_0000, 1'b0);
        // Fill the table with maximal tickets, then overfill it.
        for (n = 0; n < TABLE_DEPTH - 2; n++) begin
            add_word(ltp_pkg::FUNC_ENQ, ltp_pkg::ID_W'(8'h10 + n), 16'hFFFF, $urandom(),
                     1'b0);
        end
        add_word(ltp_pkg::FUNC_ENQ, 8'hAA, 16'h1234, 32'h0000_0000, 1'b0);
        add_word(ltp_pkg::FUNC_PICK, 8'h00, 16'h0000, 32'hFFFF_FFFF, 1'b0);
        // Removal from the middle, then a miss on a full-ish table.
        add_word(ltp_pkg::FUNC_DEQ, 8'h17, 16'h0000, 32'h0000_0000, 1'b0);
        add_word(ltp_pkg::FUNC_DEQ, 8'hEE, 16'h0000, 32'h0000_0000, 1'b0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (p = 0; p < NUM_PHASES; p++) begin
            while (pending_words.size() != 0) @(posedge aclk);
            sender_idle_pct <= sender_pct[p];
            receiver_stall_pct <= receiver_pct[p];
            // The first word of each phase waits until every result is back.
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                add_random_word(n == 0 || $urandom_range(199) == 0);
            end
        end

        while (pending_words.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== lottery_task_picker_top.f =====
design/ltp_pkg.sv
design/ltp_ram.sv
design/ltp_alu.sv
design/lottery_task_picker_top.sv
tb/testbench.sv
